### sv/gdcr_pkg.sv
// shared constants and types for the grid dda column raycaster
`default_nettype none
package gdcr_pkg;
	localparam int GRID_SIZE = 64;
	localparam int GRID_W = $clog2(GRID_SIZE);
	localparam int MAX_STEPS = 128;
	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int CELL_AW = 2 * GRID_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_EYE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EYE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLN_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLN_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST = 1'b1;

	localparam logic [1:0] OUT_HIT = 2'd0;
	localparam logic [1:0] OUT_EDGE = 2'd1;
	localparam logic [1:0] OUT_LIMIT = 2'd2;

	localparam logic [39:0] DELTA_SAT = 40'hFF_FFFF_FFFF;
	localparam logic [23:0] DIST_MAX = 24'hFF_FFFF;

	// queued command word between front and back
	typedef struct packed {
		logic op;
		logic [10:0] column;
		logic [GRID_W-1:0] cell_x;
		logic [GRID_W-1:0] cell_y;
		logic cell_wall;
	} cmd_t;

	// result word
	typedef struct packed {
		logic [23:0] wall_dist;
		logic hit_side;
		logic [5:0] hit_x;
		logic [5:0] hit_y;
		logic [15:0] slice_height;
		logic [10:0] draw_top;
		logic [10:0] draw_bottom;
		logic [1:0] outcome;
	} res_t;
endpackage
`default_nettype wire

### sv/gdcr_front.sv
// front: accepts input words and queues them as commands
`default_nettype none
module gdcr_front import gdcr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire cmd_t in_cmd,
	output logic q_valid,
	input wire logic q_pop,
	output cmd_t q_cmd
);
	localparam int DEPTH = 4;
	cmd_t mem_q [DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 3'(DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 3'd0);
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (q_pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(q_pop);
		end
	end
endmodule
`default_nettype wire

### sv/gdcr_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module gdcr_div import gdcr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] num,
	input wire logic [39:0] den,
	output logic busy,
	output logic [63:0] quo
);
	logic [6:0] cnt_q;
	logic [63:0] n_q;
	logic [40:0] rem_q;
	logic [39:0] d_q;
	logic [40:0] trial;

	assign busy = (cnt_q != 7'd0);
	assign quo = n_q;
	assign trial = {rem_q[39:0], n_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			rem_q <= '0;
			d_q <= den;
		end else if (busy) begin
			if (trial >= {1'b0, d_q}) begin
				rem_q <= trial - {1'b0, d_q};
				n_q <= {n_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				n_q <= {n_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### sv/gdcr_back.sv
// back: grid memory, ray setup sequencer and dda walk
`default_nettype none
module gdcr_back import gdcr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire cmd_t q_cmd,
	input wire logic [21:0] eye_x,
	input wire logic [21:0] eye_y,
	input wire logic signed [18:0] dir_x,
	input wire logic signed [18:0] dir_y,
	input wire logic signed [18:0] pln_x,
	input wire logic signed [18:0] pln_y,
	input wire logic [11:0] width,
	input wire logic [11:0] height,
	output logic res_valid,
	input wire logic res_take,
	output res_t res
);
	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CAM, S_RAY, S_SQ, S_SQRT, S_DX, S_DXW, S_DY, S_DYW,
		S_SIDE, S_WALK, S_RD, S_TEST, S_DIST, S_DISTW, S_SLICE, S_SLICEW,
		S_ROWS, S_OUT
	} state_t;

	state_t state_q;
	logic grid_q [GRID_SIZE*GRID_SIZE];
	logic rd_s1;
	logic [CELL_AW-1:0] clr_q;

	cmd_t cmd_q;
	logic [11:0] w_q, h_q;
	logic signed [29:0] cam_q;
	logic signed [40:0] rx_q, ry_q;
	logic [63:0] rem_sq_q, root_q, bit_q;
	logic [39:0] dx_q, dy_q;
	logic [47:0] sdx_q, sdy_q;
	logic signed [9:0] mx_q, my_q;
	logic [GRID_W-1:0] lx_q, ly_q;
	logic sx_neg_q, sy_neg_q, side_q;
	logic [1:0] outc_q;
	logic [STEP_W-1:0] n_q;
	logic [23:0] dist_q;
	logic [15:0] lh_q;

	logic dv_start, dv_busy;
	logic [63:0] dv_num, dv_quo;
	logic [39:0] dv_den;

	gdcr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num),
		.den(dv_den), .busy(dv_busy), .quo(dv_quo)
	);

	logic [40:0] mrx, mry;
	assign mrx = rx_q[40] ? 41'(-rx_q) : 41'(rx_q);
	assign mry = ry_q[40] ? 41'(-ry_q) : 41'(ry_q);

	// dda step decision and next cell
	logic step_x;
	logic signed [9:0] nmx, nmy;
	logic out_grid;
	assign step_x = sdx_q < sdy_q;
	assign nmx = step_x ? (sx_neg_q ? mx_q - 10'sd1 : mx_q + 10'sd1) : mx_q;
	assign nmy = step_x ? my_q : (sy_neg_q ? my_q - 10'sd1 : my_q + 10'sd1);
	assign out_grid = nmx < 0 || nmy < 0 || nmx >= 10'(GRID_SIZE) || nmy >= 10'(GRID_SIZE);

	// distance numerator
	logic signed [31:0] num_s;
	logic [31:0] num_m;
	always_comb begin
		if (!side_q)
			num_s = 32'(mx_q) * 32'sd65536 - 32'(signed'({1'b0, eye_x}))
				+ (sx_neg_q ? 32'sd65536 : 32'sd0);
		else
			num_s = 32'(my_q) * 32'sd65536 - 32'(signed'({1'b0, eye_y}))
				+ (sy_neg_q ? 32'sd65536 : 32'sd0);
		num_m = num_s[31] ? 32'(-num_s) : 32'(num_s);
	end

	// sqrt trial and squared ray length, ray components stay below 2^31
	logic [63:0] sq_trial;
	logic [63:0] sq_in;
	assign sq_trial = root_q + bit_q;
	assign sq_in = 64'(mrx[30:0]) * 64'(mrx[30:0]) + 64'(mry[30:0]) * 64'(mry[30:0]);

	// multiply operands for cam products and side distances
	logic signed [48:0] prx, pry;
	assign prx = pln_x * cam_q;
	assign pry = pln_y * cam_q;

	logic [16:0] fx, fy;
	assign fx = rx_q[40] ? {1'b0, eye_x[15:0]} : 17'h10000 - {1'b0, eye_x[15:0]};
	assign fy = ry_q[40] ? {1'b0, eye_y[15:0]} : 17'h10000 - {1'b0, eye_y[15:0]};

	logic [10:0] hh, lhh;
	logic [12:0] top_s, bot_s;
	logic [11:0] bot_c;
	assign hh = h_q[11:1];
	assign lhh = 11'(lh_q[15:1] > 15'd2047 ? 15'd2047 : lh_q[15:1]);
	assign bot_c = (bot_s >= {1'b0, h_q}) ? h_q - 12'd1 : bot_s[11:0];

	always_comb begin
		dv_start = 1'b0;
		dv_num = '0;
		dv_den = 40'd1;
		unique case (state_q)
			S_CAM: begin
				dv_start = 1'b1;
				dv_num = {36'd0, cmd_q.column, 17'd0};
				dv_den = {28'd0, w_q};
			end
			S_DX: begin
				dv_start = mrx != 0;
				dv_num = root_q << 16;
				dv_den = mrx[39:0];
			end
			S_DY: begin
				dv_start = mry != 0;
				dv_num = root_q << 16;
				dv_den = mry[39:0];
			end
			S_DIST: begin
				dv_start = (side_q ? mry : mrx) != 0;
				dv_num = {16'd0, num_m, 16'd0};
				dv_den = side_q ? mry[39:0] : mrx[39:0];
			end
			S_SLICE: begin
				dv_start = 1'b1;
				dv_num = {36'd0, h_q, 16'd0};
				dv_den = {16'd0, dist_q};
			end
			default: ;
		endcase
		top_s = {2'b0, hh} - {2'b0, lhh};
		bot_s = {2'b0, lhh} + {2'b0, hh};
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign res_valid = (state_q == S_OUT);

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) grid_q[clr_q] <= 1'b0;
		else if (q_pop && q_cmd.op == OP_WRITE)
			grid_q[{q_cmd.cell_x, q_cmd.cell_y}] <= q_cmd.cell_wall;
		rd_s1 <= grid_q[{mx_q[GRID_W-1:0], my_q[GRID_W-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: if (q_valid && q_cmd.op == OP_CAST) begin
					cmd_q <= q_cmd;
					w_q <= width == 0 ? 12'd1 : width;
					h_q <= height == 0 ? 12'd1 : height;
					if (eye_x[21:16] >= 6'(GRID_SIZE-1) + 6'd1 && GRID_SIZE < 64
						|| eye_y[21:16] >= 6'(GRID_SIZE-1) + 6'd1 && GRID_SIZE < 64) begin
						res <= '{wall_dist: '0, hit_side: 1'b0, hit_x: '0, hit_y: '0,
							slice_height: '0, draw_top: '0, draw_bottom: '0,
							outcome: OUT_EDGE};
						state_q <= S_OUT;
					end else state_q <= S_CAM;
				end
				S_CAM: state_q <= S_RAY;
				S_RAY: if (!dv_busy && !dv_start) begin
					cam_q <= signed'(dv_quo[29:0] - 30'd65536);
					state_q <= S_SQ;
				end
				S_SQ: begin
					rx_q <= 41'(dir_x) + 41'(prx / 49'sd65536);
					ry_q <= 41'(dir_y) + 41'(pry / 49'sd65536);
					state_q <= S_SQRT;
					bit_q <= '0;
				end
				S_SQRT: begin
					if (bit_q == 0) begin
						rem_sq_q <= sq_in;
						root_q <= '0;
						bit_q <= 64'd1 << 62;
					end else begin
						if (rem_sq_q >= sq_trial) begin
							rem_sq_q <= rem_sq_q - sq_trial;
							root_q <= (root_q >> 1) + bit_q;
						end else root_q <= root_q >> 1;
						bit_q <= bit_q >> 2;
						if (bit_q == 64'd1) state_q <= S_DX;
					end
				end
				S_DX: begin
					if (mrx == 0) begin
						dx_q <= DELTA_SAT;
						state_q <= S_DY;
					end else state_q <= S_DXW;
				end
				S_DXW: if (!dv_busy) begin
					dx_q <= dv_quo > 64'(DELTA_SAT) ? DELTA_SAT : dv_quo[39:0];
					state_q <= S_DY;
				end
				S_DY: begin
					if (mry == 0) begin
						dy_q <= DELTA_SAT;
						state_q <= S_SIDE;
					end else state_q <= S_DYW;
				end
				S_DYW: if (!dv_busy) begin
					dy_q <= dv_quo > 64'(DELTA_SAT) ? DELTA_SAT : dv_quo[39:0];
					state_q <= S_SIDE;
				end
				S_SIDE: begin
					sdx_q <= 48'((57'(fx) * 57'(dx_q)) >> 16);
					sdy_q <= 48'((57'(fy) * 57'(dy_q)) >> 16);
					sx_neg_q <= rx_q[40];
					sy_neg_q <= ry_q[40];
					mx_q <= 10'(eye_x[21:16]);
					my_q <= 10'(eye_y[21:16]);
					lx_q <= eye_x[16+:GRID_W];
					ly_q <= eye_y[16+:GRID_W];
					side_q <= 1'b0;
					n_q <= '0;
					outc_q <= OUT_LIMIT;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (n_q == STEP_W'(MAX_STEPS)) state_q <= S_DIST;
					else begin
						if (step_x) sdx_q <= sdx_q + 48'(dx_q);
						else sdy_q <= sdy_q + 48'(dy_q);
						side_q <= !step_x;
						mx_q <= nmx;
						my_q <= nmy;
						n_q <= n_q + 1'b1;
						if (out_grid) begin
							outc_q <= OUT_EDGE;
							state_q <= S_DIST;
						end else state_q <= S_RD;
					end
				end
				S_RD: begin
					lx_q <= mx_q[GRID_W-1:0];
					ly_q <= my_q[GRID_W-1:0];
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (rd_s1) begin
						outc_q <= OUT_HIT;
						state_q <= S_DIST;
					end else state_q <= S_WALK;
				end
				S_DIST: state_q <= S_DISTW;
				S_DISTW: if (!dv_busy) begin
					if ((side_q ? mry : mrx) == 0 || dv_quo > 64'(DIST_MAX))
						dist_q <= DIST_MAX;
					else if (dv_quo == 0) dist_q <= 24'h010000;
					else dist_q <= dv_quo[23:0];
					state_q <= S_SLICE;
				end
				S_SLICE: state_q <= S_SLICEW;
				S_SLICEW: if (!dv_busy) begin
					lh_q <= dv_quo > 64'd65535 ? 16'hFFFF : dv_quo[15:0];
					state_q <= S_ROWS;
				end
				S_ROWS: begin
					res.wall_dist <= dist_q;
					res.hit_side <= side_q;
					res.hit_x <= 6'(lx_q);
					res.hit_y <= 6'(ly_q);
					res.slice_height <= lh_q;
					res.draw_top <= top_s[12] ? 11'd0 : top_s[10:0];
					// clamp at height minus 1, then at the last 11-bit row
					res.draw_bottom <= bot_c[11] ? 11'd2047 : bot_c[10:0];
					res.outcome <= outc_q;
					state_q <= S_OUT;
				end
				S_OUT: if (res_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/grid_dda_column_raycaster_unit.sv
// top level of the grid dda column raycaster
// A write word (op 0) stores one cell of the 64x64 wall grid; a cast word (op 1) returns
// one result word for a screen column. After reset a clearing pass sweeps the grid,
// during which at most four words are queued and no word is carried out
// (configuration writes are accepted). In a cast a shared bit-serial divider runs up
// to five times (camera, two deltas, distance, slice), a square root runs once, and
// the dda walk passes through a step, a grid memory read and a test state per cell.
// A four-entry queue separates the input side from the sequencer.
`default_nettype none
module grid_dda_column_raycaster_unit import gdcr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic op,
	input wire logic [10:0] column,
	input wire logic [5:0] cell_x,
	input wire logic [5:0] cell_y,
	input wire logic cell_wall,
	output logic out_valid,
	input wire logic out_stall,
	output logic [23:0] wall_dist,
	output logic hit_side,
	output logic [5:0] hit_x,
	output logic [5:0] hit_y,
	output logic [15:0] slice_height,
	output logic [10:0] draw_top,
	output logic [10:0] draw_bottom,
	output logic [1:0] outcome,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	// configuration registers
	logic [21:0] eye_x_q, eye_y_q;
	logic signed [18:0] dir_x_q, dir_y_q, pln_x_q, pln_y_q;
	logic [11:0] width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q <= 22'd98304;
			eye_y_q <= 22'd98304;
			dir_x_q <= 19'sd65536;
			dir_y_q <= '0;
			pln_x_q <= '0;
			pln_y_q <= 19'sd43254;
			width_q <= 12'd640;
			height_q <= 12'd480;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_EYE_X: eye_x_q <= cfg_data[21:0];
				REG_EYE_Y: eye_y_q <= cfg_data[21:0];
				REG_DIR_X: dir_x_q <= cfg_data[18:0];
				REG_DIR_Y: dir_y_q <= cfg_data[18:0];
				REG_PLN_X: pln_x_q <= cfg_data[18:0];
				REG_PLN_Y: pln_y_q <= cfg_data[18:0];
				REG_WIDTH: width_q <= cfg_data[11:0];
				REG_HEIGHT: height_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_pop;
	assign in_cmd = '{op: op, column: column, cell_x: cell_x, cell_y: cell_y,
		cell_wall: cell_wall};

	gdcr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
	);

	// result word is held in the back end until the sink takes it
	res_t res;
	logic res_valid;

	gdcr_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
		.eye_x(eye_x_q), .eye_y(eye_y_q), .dir_x(dir_x_q), .dir_y(dir_y_q),
		.pln_x(pln_x_q), .pln_y(pln_y_q), .width(width_q), .height(height_q),
		.res_valid(res_valid), .res_take(!out_stall), .res(res)
	);

	assign out_valid = res_valid;
	assign wall_dist = res.wall_dist;
	assign hit_side = res.hit_side;
	assign hit_x = res.hit_x;
	assign hit_y = res.hit_y;
	assign slice_height = res.slice_height;
	assign draw_top = res.draw_top;
	assign draw_bottom = res.draw_bottom;
	assign outcome = res.outcome;

	// an outcome code above step limit never leaves the block
	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome == OUT_HIT || outcome == OUT_EDGE || outcome == OUT_LIMIT))
		else $error("bad outcome code");
	// a wall hit never reports a zero distance
	a_dist_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_HIT |-> wall_dist != 24'd0)
		else $error("zero distance on hit");
	// bottom row never below top row on a hit with a slice height of two or more
	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_HIT |-> draw_bottom >= draw_top || slice_height < 16'd2)
		else $error("rows inverted");
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench for the grid dda column raycaster unit
`default_nettype none
module tb_top;
	import gdcr_pkg::*;

	// clock, reset and block ports
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic op;
	logic [10:0] column;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic cell_wall;
	logic out_valid;
	logic out_stall;
	logic [23:0] wall_dist;
	logic hit_side;
	logic [5:0] hit_x;
	logic [5:0] hit_y;
	logic [15:0] slice_height;
	logic [10:0] draw_top;
	logic [10:0] draw_bottom;
	logic [1:0] outcome;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	grid_dda_column_raycaster_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .column(column), .cell_x(cell_x), .cell_y(cell_y), .cell_wall(cell_wall),
		.out_valid(out_valid), .out_stall(out_stall),
		.wall_dist(wall_dist), .hit_side(hit_side), .hit_x(hit_x), .hit_y(hit_y),
		.slice_height(slice_height), .draw_top(draw_top), .draw_bottom(draw_bottom),
		.outcome(outcome),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the view registers and the wall map
	logic [21:0] eye_x_q;
	logic [21:0] eye_y_q;
	logic signed [18:0] dir_x_q;
	logic signed [18:0] dir_y_q;
	logic signed [18:0] pln_x_q;
	logic signed [18:0] pln_y_q;
	logic [11:0] width_q;
	logic [11:0] height_q;
	logic wall_map [GRID_SIZE][GRID_SIZE];

	cmd_t pending_words[$];   // words not yet offered to the block
	res_t casts_due[$];       // predicted cast results, oldest first
	int errors;
	logic word_taken;         // word on the input port was taken at the last edge
	int burst_left;
	int gap_left;
	bit quiet;
	int stall_mode;
	int stall_timer;

	// integer square root, one result bit per pass
	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	function automatic longint unsigned abs64(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// per-axis step length; zero component or overflow saturates
	function automatic longint unsigned step_len(input longint unsigned len,
			input longint unsigned comp);
		longint unsigned d;
		if (comp == 0)
			return 64'(DELTA_SAT);
		d = (len << 16) / comp;
		return (d > 64'(DELTA_SAT)) ? 64'(DELTA_SAT) : d;
	endfunction

	// expected result of casting one column against the shadow state
	function automatic res_t cast_ray(input logic [10:0] col);
		longint w, h, cam, rx, ry, mx, my, lx, ly, sx, sy, num, lh, top, bot;
		longint unsigned len, dx, dy, sdx, sdy, den, perp, ex, ey;
		logic side;
		logic [1:0] oc;
		res_t r;
		r = '0;
		side = 1'b0;
		oc = OUT_LIMIT;
		ex = eye_x_q;
		ey = eye_y_q;
		mx = longint'(ex >> 16);
		my = longint'(ey >> 16);
		// viewer outside the grid: nothing but the edge flag
		if (mx >= GRID_SIZE || my >= GRID_SIZE) begin
			r.outcome = OUT_EDGE;
			return r;
		end
		w = (width_q == 0) ? 1 : longint'(width_q);
		h = (height_q == 0) ? 1 : longint'(height_q);
		cam = (longint'(col) * 2 * 65536) / w - 65536;
		rx = longint'(dir_x_q) + longint'(pln_x_q) * cam / 65536;
		ry = longint'(dir_y_q) + longint'(pln_y_q) * cam / 65536;
		len = root_floor(abs64(rx) * abs64(rx) + abs64(ry) * abs64(ry));
		dx = step_len(len, abs64(rx));
		dy = step_len(len, abs64(ry));
		if (rx < 0) begin
			sx = -1;
			sdx = ((ex - (longint'(mx) << 16)) * dx) >> 16;
		end else begin
			sx = 1;
			sdx = (((longint'(mx) + 1) << 16) - ex) * dx >> 16;
		end
		if (ry < 0) begin
			sy = -1;
			sdy = ((ey - (longint'(my) << 16)) * dy) >> 16;
		end else begin
			sy = 1;
			sdy = (((longint'(my) + 1) << 16) - ey) * dy >> 16;
		end
		lx = mx;
		ly = my;
		// grid walk, y steps on a tie, start cell never tested
		for (int n = 0; n < MAX_STEPS; n++) begin
			if (sdx < sdy) begin
				sdx += dx;
				mx += sx;
				side = 1'b0;
			end else begin
				sdy += dy;
				my += sy;
				side = 1'b1;
			end
			if (mx < 0 || my < 0 || mx >= GRID_SIZE || my >= GRID_SIZE) begin
				oc = OUT_EDGE;
				break;
			end
			lx = mx;
			ly = my;
			if (wall_map[mx][my]) begin
				oc = OUT_HIT;
				break;
			end
		end
		if (!side) begin
			num = mx * 65536 - longint'(ex) + ((sx < 0) ? 65536 : 0);
			den = abs64(rx);
		end else begin
			num = my * 65536 - longint'(ey) + ((sy < 0) ? 65536 : 0);
			den = abs64(ry);
		end
		if (den == 0)
			perp = 64'(DIST_MAX);
		else begin
			perp = (abs64(num) << 16) / den;
			if (perp > 64'(DIST_MAX))
				perp = 64'(DIST_MAX);
		end
		// zero distance counts as one cell
		if (perp == 0)
			perp = 65536;
		lh = longint'((longint'(h) << 16) / perp);
		if (lh > 65535)
			lh = 65535;
		top = h / 2 - lh / 2;
		if (top < 0)
			top = 0;
		bot = lh / 2 + h / 2;
		if (bot >= h)
			bot = h - 1;
		if (bot > 2047)
			bot = 2047;
		r.wall_dist = perp[23:0];
		r.hit_side = side;
		r.hit_x = lx[5:0];
		r.hit_y = ly[5:0];
		r.slice_height = lh[15:0];
		r.draw_top = top[10:0];
		r.draw_bottom = bot[10:0];
		r.outcome = oc;
		return r;
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// timeout guard
	initial begin
		#120000000;
		$display("tb_top: done, errors");
		$finish;
	end

	// input side: note taken words, predict casts, track cell writes and reg writes
	always @(posedge clk) begin
		word_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			if (op == OP_CAST)
				casts_due.push_back(cast_ray(column));
			else
				wall_map[cell_x][cell_y] = cell_wall;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EYE_X: eye_x_q = cfg_data[21:0];
				REG_EYE_Y: eye_y_q = cfg_data[21:0];
				REG_DIR_X: dir_x_q = cfg_data[18:0];
				REG_DIR_Y: dir_y_q = cfg_data[18:0];
				REG_PLN_X: pln_x_q = cfg_data[18:0];
				REG_PLN_Y: pln_y_q = cfg_data[18:0];
				REG_WIDTH: width_q = cfg_data[11:0];
				REG_HEIGHT: height_q = cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// output side: compare each result word with the oldest prediction
	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (casts_due.size() == 0) begin
				$display("%0t result word with none expected: dist %0d outcome %0d",
					$time, wall_dist, outcome);
				errors++;
			end else begin
				e = casts_due.pop_front();
				check_field("wall_dist", e.wall_dist, wall_dist);
				check_field("hit_side", e.hit_side, hit_side);
				check_field("hit_x", e.hit_x, hit_x);
				check_field("hit_y", e.hit_y, hit_y);
				check_field("slice_height", e.slice_height, slice_height);
				check_field("draw_top", e.draw_top, draw_top);
				check_field("draw_bottom", e.draw_bottom, draw_bottom);
				check_field("outcome", e.outcome, outcome);
			end
		end
	end

	// driver: bursts of words with random gaps; receiver stall in changing modes
	always @(negedge clk) begin
		cmd_t c;
		if (arst_n) begin
			if (!in_valid || word_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					c = pending_words.pop_front();
					op <= c.op;
					column <= c.column;
					cell_x <= c.cell_x;
					cell_y <= c.cell_y;
					cell_wall <= c.cell_wall;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						quiet = ($urandom_range(0, 3) == 0);
						gap_left = quiet ? 0 : $urandom_range(0, 5);
					end else
						burst_left--;
				end else
					in_valid <= 1'b0;
			end
			if (stall_timer == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_timer = $urandom_range(16, 200);
			end else
				stall_timer--;
			case (stall_mode)
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic push_cast(input int col);
		cmd_t c;
		c = '0;
		c.op = OP_CAST;
		c.column = col[10:0];
		c.cell_x = 6'($urandom);
		c.cell_y = 6'($urandom);
		c.cell_wall = 1'($urandom);
		pending_words.push_back(c);
	endtask

	task automatic push_cell(input int x, input int y, input bit wall);
		cmd_t c;
		c = '0;
		c.op = OP_WRITE;
		c.column = 11'($urandom);
		c.cell_x = x[5:0];
		c.cell_y = y[5:0];
		c.cell_wall = wall;
		pending_words.push_back(c);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// full view setup, only while the block is idle
	task automatic load_view(input int ex, input int ey, input int dx, input int dy,
			input int px, input int py, input int w, input int h);
		write_reg(REG_EYE_X, ex);
		write_reg(REG_EYE_Y, ey);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_PLN_X, px);
		write_reg(REG_PLN_Y, py);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off until every word is in and every result is out, then let writes drain
	task automatic settle();
		while (pending_words.size() > 0 || in_valid || casts_due.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// random mix of cell writes and casts
	task automatic random_phase(input int count, input int wall_pct, input int w);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 40)
				push_cell($urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 99) < wall_pct);
			else if ($urandom_range(0, 9) == 0)
				push_cast($urandom_range(0, 2047));
			else
				push_cast($urandom_range(0, w - 1));
		end
	endtask

	initial begin
		int w;
		errors = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_WRITE;
		column = '0;
		cell_x = '0;
		cell_y = '0;
		cell_wall = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		gap_left = 0;
		quiet = 0;
		stall_mode = 0;
		stall_timer = 0;
		eye_x_q = 22'd98304;
		eye_y_q = 22'd98304;
		dir_x_q = 19'sd65536;
		dir_y_q = '0;
		pln_x_q = '0;
		pln_y_q = 19'sd43254;
		width_q = 12'd640;
		height_q = 12'd480;
		foreach (wall_map[i, j])
			wall_map[i][j] = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty grid leaves at the edge, then walls at the corners and ahead
		push_cast(0);
		push_cast(320);
		push_cast(639);
		push_cast(2047);
		push_cell(10, 1, 1'b1);
		push_cell(0, 0, 1'b1);
		push_cell(63, 63, 1'b1);
		push_cast(320);
		push_cell(63, 63, 1'b0);
		push_cell(2, 0, 1'b1);
		push_cell(0, 2, 1'b1);
		push_cast(0);
		push_cast(639);
		settle();

		// eye on a cell corner looking toward -x: zero distance case
		load_view(5 << 16, 7 << 16, -65536, 0, 0, 43254, 640, 480);
		push_cell(4, 7, 1'b1);
		push_cast(320);
		push_cast(0);
		push_cast(639);
		random_phase(260, 30, 640);
		settle();

		// far corner, extreme directions, widest screen
		load_view(4194303, 4194303, -131072, -131072, 131072, -131072, 2048, 2048);
		push_cast(0);
		push_cast(1024);
		push_cast(2047);
		random_phase(260, 30, 2048);
		settle();

		// origin, diagonal view without plane: side distances tie, one row and column
		load_view(0, 0, 131072, 131072, 0, 0, 1, 1);
		push_cast(0);
		push_cast(2047);
		random_phase(200, 25, 1);
		settle();

		// zero ray, zero screen size treated as one
		load_view(3 << 16 | 16'h8000, 40 << 16, 0, 0, 0, 0, 0, 0);
		push_cast(0);
		push_cast(5);
		random_phase(60, 30, 4);
		settle();

		// closed box of walls around the eye, then random cell writes and casts
		load_view(32 << 16 | 16'h1234, 30 << 16 | 16'hABCD, 46341, 46341, -30000, 30000,
			320, 200);
		for (int k = 0; k < GRID_SIZE; k++) begin
			push_cell(k, 0, 1'b1);
			push_cell(k, 63, 1'b1);
			push_cell(0, k, 1'b1);
			push_cell(63, k, 1'b1);
		end
		random_phase(200, 15, 320);
		settle();

		// random views, mostly small screens
		for (int p = 0; p < 4; p++) begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 64);
			load_view($urandom_range(0, 4194303), $urandom_range(0, 4194303),
				int'($urandom_range(0, 262144)) - 131072,
				int'($urandom_range(0, 262144)) - 131072,
				int'($urandom_range(0, 262144)) - 131072,
				int'($urandom_range(0, 262144)) - 131072,
				w, $urandom_range(1, 2048));
			random_phase(172, 20 + 10 * p, w);
			settle();
		end

		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
